>>> rtl/hci_frm_pkg.sv
// Shared constants and types of the H4 packet framer.
`default_nettype none
package hci_frm_pkg;

    localparam int MAX_PACKET = 2048;
    // Packet byte counter: holds 0 .. MAX_PACKET.
    localparam int CNT_W      = $clog2(MAX_PACKET + 1);
    // Unsaturated length: type + 4 preamble bytes + 16-bit payload length.
    localparam int LEN_W      = 17;

    localparam logic [7:0] TYPE_CMD = 8'h01;
    localparam logic [7:0] TYPE_ACL = 8'h02;
    localparam logic [7:0] TYPE_SCO = 8'h03;
    localparam logic [1:0] KIND_ACL = 2'd2;

    localparam int PRE_SHORT = 3;
    localparam int PRE_LONG  = 4;
    // Index of the preamble byte that holds the (low) length byte.
    localparam int LEN_IDX   = 3;
    localparam logic [1:0] HDR_BYTES = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'b001,
        PH_PREAMBLE = 3'b010,
        PH_PAYLOAD  = 3'b100
    } t_phase;

    // Result of one word, handed from the framing core to the output stage.
    typedef struct packed {
        logic       load;   // a result word group is produced
        logic       burst;  // precede the word with the zero header bytes
        logic [7:0] data;
        logic       pend;   // word completes the packet
    } t_result;

endpackage
`default_nettype wire

>>> rtl/hci_frm_input.sv
// Input register of the H4 packet framer.
`default_nettype none
module hci_frm_input (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_take,
    output logic            o_held,
    output logic [7:0]      o_byte
);
    import hci_frm_pkg::*;

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_held  = r_valid;
    assign o_byte  = r_byte;

    always_comb begin
        n_valid = r_valid;
        if (i_take) begin
            n_valid = 1'b0;
        end
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_in_byte;
        end
    end

endmodule
`default_nettype wire

>>> rtl/hci_frm_core.sv
// Framing state and per-word decision of the H4 packet framer.
`default_nettype none
module hci_frm_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_held,
    input  wire logic [7:0]            i_byte,
    input  wire logic                  i_can_load,
    output logic                       o_take,
    output hci_frm_pkg::t_result       o_result
);
    import hci_frm_pkg::*;

    t_phase             r_phase, n_phase;
    logic [1:0]         r_kind, n_kind;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_total, n_total;
    logic [7:0]         r_low, n_low;

    logic               drop;
    logic [CNT_W-1:0]   count_inc;
    logic [CNT_W-1:0]   pre;
    logic [7:0]         len_lo;
    logic [LEN_W-1:0]   len_full;
    logic [CNT_W-1:0]   len_sat;
    logic               is_type;

    assign is_type   = (i_byte == TYPE_CMD) || (i_byte == TYPE_ACL) || (i_byte == TYPE_SCO);
    assign count_inc = r_count + CNT_W'(1);
    assign pre       = (r_kind == KIND_ACL) ? CNT_W'(PRE_LONG) : CNT_W'(PRE_SHORT);
    // Length byte may arrive in this very word.
    assign len_lo    = (r_count == CNT_W'(LEN_IDX)) ? i_byte : r_low;

    always_comb begin
        if (r_kind == KIND_ACL) begin
            len_full = LEN_W'(1) + LEN_W'(pre) + LEN_W'({i_byte, len_lo});
        end else begin
            len_full = LEN_W'(1) + LEN_W'(pre) + LEN_W'(len_lo);
        end
        if (len_full > LEN_W'(MAX_PACKET)) begin
            len_sat = CNT_W'(MAX_PACKET);
        end else begin
            len_sat = CNT_W'(len_full);
        end
    end

    assign drop   = (r_phase == PH_IDLE) && !is_type;
    assign o_take = i_held && (drop || i_can_load);

    always_comb begin
        n_phase         = r_phase;
        n_kind          = r_kind;
        n_count         = r_count;
        n_total         = r_total;
        n_low           = r_low;
        o_result.load   = 1'b0;
        o_result.burst  = 1'b0;
        o_result.data   = i_byte;
        o_result.pend   = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (is_type) begin
                    o_result.load  = 1'b1;
                    o_result.burst = 1'b1;
                    n_kind         = i_byte[1:0];
                    n_count        = CNT_W'(1);
                    n_total        = '0;
                    n_low          = '0;
                    n_phase        = PH_PREAMBLE;
                end
            end
            PH_PREAMBLE: begin
                o_result.load = 1'b1;
                n_count       = count_inc;
                if (r_count == CNT_W'(LEN_IDX)) begin
                    n_low = i_byte;
                end
                if (r_count >= pre) begin
                    n_total = len_sat;
                    if (count_inc >= len_sat) begin
                        o_result.pend = 1'b1;
                        n_count       = '0;
                        n_phase       = PH_IDLE;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                o_result.load = 1'b1;
                n_count       = count_inc;
                if (count_inc >= r_total) begin
                    o_result.pend = 1'b1;
                    n_count       = '0;
                    n_phase       = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        if (!i_held) begin
            o_result.load = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_kind  <= '0;
            r_count <= '0;
            r_total <= '0;
            r_low   <= '0;
        end else if (o_take) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_count <= n_count;
            r_total <= n_total;
            r_low   <= n_low;
        end
    end

endmodule
`default_nettype wire

>>> rtl/hci_frm_emit.sv
// Output register of the H4 packet framer: plays out the zero header bytes.
`default_nettype none
module hci_frm_emit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire hci_frm_pkg::t_result  i_result,
    input  wire logic                  i_take,
    output logic                       o_can_load,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [7:0]                 o_out_byte,
    output logic                       o_packet_end,
    output logic                       o_run_end
);
    import hci_frm_pkg::*;

    logic       r_valid, n_valid;
    logic [1:0] r_hdr_left, n_hdr_left;
    logic [7:0] r_data;
    logic       r_pend;
    logic       last;
    logic       load;

    assign last       = (r_hdr_left == 2'd0);
    assign o_can_load = !r_valid || (i_ready && last);
    assign load       = i_take && i_result.load;

    assign o_valid      = r_valid;
    assign o_out_byte   = last ? r_data : 8'h00;
    assign o_packet_end = last && r_pend;
    assign o_run_end    = last;

    always_comb begin
        n_valid    = r_valid;
        n_hdr_left = r_hdr_left;
        if (r_valid && i_ready) begin
            if (last) begin
                n_valid = 1'b0;
            end else begin
                n_hdr_left = r_hdr_left - 2'd1;
            end
        end
        if (load) begin
            n_valid    = 1'b1;
            n_hdr_left = i_result.burst ? HDR_BYTES : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_hdr_left <= '0;
        end else begin
            r_valid    <= n_valid;
            r_hdr_left <= n_hdr_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_result.data;
            r_pend <= i_result.pend;
        end
    end

endmodule
`default_nettype wire

>>> rtl/hci_h4_packet_framer.sv
// Top level of the H4 packet framer.
//
//   channel | valid   | ready   | payload
//   --------+---------+---------+-------------------------------------------
//   input   | i_valid | o_ready | i_in_byte
//   output  | o_valid | i_ready | o_out_byte, o_packet_end, o_run_end
//
// A byte passes input register, framing logic and output register; one word
// per cycle is sustained while the packet streams and the output is ready.
// A type byte holds the output register for three zero header bytes, then
// the type byte; the input register takes one further byte.
// Unknown type bytes are consumed with no output word.
// Synchronous active-low reset returns the framer to idle and empties both
// registers. Output stalls back up through the input register.
`default_nettype none
module hci_h4_packet_framer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_in_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_packet_end,
    output logic            o_run_end
);
    import hci_frm_pkg::*;

    logic       take;
    logic       held;
    logic [7:0] held_byte;
    logic       can_load;
    t_result    result;

    hci_frm_input u_input (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_in_byte (i_in_byte),
        .i_take    (take),
        .o_held    (held),
        .o_byte    (held_byte)
    );

    hci_frm_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_held     (held),
        .i_byte     (held_byte),
        .i_can_load (can_load),
        .o_take     (take),
        .o_result   (result)
    );

    hci_frm_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_result     (result),
        .i_take       (take),
        .o_can_load   (can_load),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_packet_end (o_packet_end),
        .o_run_end    (o_run_end)
    );

endmodule
`default_nettype wire

>>> tb/sv/tb_hci_h4_packet_framer.sv
// Self-checking testbench of the H4 packet framer: queued host bytes against predicted words.
`timescale 1ns / 100ps
module tb_hci_h4_packet_framer;
    import hci_frm_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       pend;
        logic       rend;
    } t_ctrl_word;

    typedef struct packed {
        logic [7:0] data;
        logic       drain;  // offer only once every expected word has arrived
    } t_host_byte;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_ready   = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_packet_end;
    logic       o_run_end;

    hci_h4_packet_framer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_packet_end (o_packet_end),
        .o_run_end    (o_run_end)
    );

    always #2 i_clk = ~i_clk;

    // Framing state mirrored from the host stream.
    t_phase      fr_phase  = PH_IDLE;
    logic [1:0]  fr_kind   = '0;
    logic [11:0] fr_count  = '0;
    logic [11:0] fr_total  = '0;
    logic [7:0]  fr_len_lo = '0;

    t_ctrl_word  ctrl_words_q[$];
    t_host_byte  host_bytes_q[$];
    int unsigned mismatches  = 0;
    int unsigned bytes_taken = 0;
    logic        in_took     = 1'b0;

    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    int unsigned hold_left  = 0;
    logic        hold_done  = 1'b0;
    int unsigned mode_left  = 0;
    int unsigned stall_mode = 0;

    function automatic void push_word(logic [7:0] d, logic pend, logic rend);
        ctrl_words_q.push_back('{d, pend, rend});
    endfunction

    function automatic void frame_byte(logic [7:0] b);
        int unsigned idx;
        int unsigned pre;
        logic [16:0] length;
        case (fr_phase)
            PH_PREAMBLE: begin
                idx = fr_count;
                pre = (fr_kind == KIND_ACL) ? PRE_LONG : PRE_SHORT;
                fr_count = fr_count + 1'b1;
                if (idx == LEN_IDX)
                    fr_len_lo = b;
                if (idx >= pre) begin
                    if (fr_kind == KIND_ACL)
                        length = 17'(1 + pre + {b, fr_len_lo});
                    else
                        length = 17'(1 + pre + fr_len_lo);
                    if (length > MAX_PACKET)
                        length = 17'(MAX_PACKET);
                    fr_total = length[11:0];
                    if (fr_count >= fr_total) begin
                        // zero payload: the last preamble byte closes the packet
                        fr_phase = PH_IDLE;
                        fr_count = '0;
                        push_word(b, 1'b1, 1'b1);
                        return;
                    end
                    fr_phase = PH_PAYLOAD;
                end
                push_word(b, 1'b0, 1'b1);
            end
            PH_PAYLOAD: begin
                fr_count = fr_count + 1'b1;
                if (fr_count >= fr_total) begin
                    fr_phase = PH_IDLE;
                    fr_count = '0;
                    push_word(b, 1'b1, 1'b1);
                end else begin
                    push_word(b, 1'b0, 1'b1);
                end
            end
            default: begin
                // drop anything that is not a known packet type
                if (b < TYPE_CMD || b > TYPE_SCO) begin
                    fr_phase = PH_IDLE;
                    return;
                end
                fr_kind   = b[1:0];
                fr_count  = 12'd1;
                fr_total  = '0;
                fr_len_lo = '0;
                fr_phase  = PH_PREAMBLE;
                for (int unsigned k = 0; k < HDR_BYTES; k++)
                    push_word(8'h00, 1'b0, 1'b0);
                push_word(b, 1'b0, 1'b1);
            end
        endcase
    endfunction

    // Queue one whole packet; returns the number of bytes queued.
    function automatic int unsigned queue_packet(logic [7:0] kind, logic [15:0] len,
                                                 logic drain);
        int unsigned pre;
        int unsigned total;
        logic [7:0]  b;
        pre   = (kind == TYPE_ACL) ? PRE_LONG : PRE_SHORT;
        total = 1 + pre + len;
        if (total > MAX_PACKET)
            total = MAX_PACKET;
        for (int unsigned i = 0; i < total; i++) begin
            case (i)
                0:        b = kind;
                LEN_IDX:  b = len[7:0];
                PRE_LONG: b = (kind == TYPE_ACL) ? len[15:8] : 8'($urandom_range(0, 255));
                default:  b = 8'($urandom_range(0, 255));
            endcase
            host_bytes_q.push_back('{b, drain && (i == 0)});
        end
        return total;
    endfunction

    // Predict on every accepted byte, then check the word leaving the block.
    always @(posedge i_clk) begin
        t_ctrl_word w;
        if (!i_rst_n) begin
            fr_phase  = PH_IDLE;
            fr_kind   = '0;
            fr_count  = '0;
            fr_total  = '0;
            fr_len_lo = '0;
        end else begin
            if (i_valid && o_ready) begin
                frame_byte(i_in_byte);
                bytes_taken++;
            end
            if (o_valid && i_ready) begin
                if (ctrl_words_q.size() == 0) begin
                    $error("unexpected word: out_byte %0h", o_out_byte);
                    mismatches++;
                end else begin
                    w = ctrl_words_q.pop_front();
                    if (o_out_byte !== w.data) begin
                        $error("out_byte: expected %0h, actual %0h", w.data, o_out_byte);
                        mismatches++;
                    end
                    if (o_packet_end !== w.pend) begin
                        $error("packet_end: expected %0b, actual %0b", w.pend, o_packet_end);
                        mismatches++;
                    end
                    if (o_run_end !== w.rend) begin
                        $error("run_end: expected %0b, actual %0b", w.rend, o_run_end);
                        mismatches++;
                    end
                end
            end
        end
        in_took <= i_rst_n && i_valid && o_ready;
    end

    // Host side: offer queued bytes in bursts with random gaps.
    always @(negedge i_clk) begin
        logic       next_valid;
        logic [7:0] next_byte;
        next_valid = i_valid;
        next_byte  = i_in_byte;
        if (i_rst_n) begin
            if (in_took) begin
                void'(host_bytes_q.pop_front());
                next_valid = 1'b0;
            end
            if (!next_valid && host_bytes_q.size() != 0) begin
                if (gap_left != 0 && hold_left == 0) begin
                    gap_left--;
                end else if (!host_bytes_q[0].drain || ctrl_words_q.size() == 0) begin
                    next_valid = 1'b1;
                    next_byte  = host_bytes_q[0].data;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
        i_valid   <= next_valid;
        i_in_byte <= next_byte;
    end

    // Controller side: stall pattern in segments, plus one long hold-off.
    always @(negedge i_clk) begin
        logic next_ready;
        if (hold_left != 0) begin
            hold_left--;
            next_ready = 1'b0;
        end else if (!hold_done && bytes_taken >= 40) begin
            hold_done  = 1'b1;
            hold_left  = 150;
            next_ready = 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left  = $urandom_range(8, 40);
                stall_mode = $urandom_range(0, 2);
            end
            mode_left--;
            case (stall_mode)
                0:       next_ready = 1'b1;
                1:       next_ready = ($urandom_range(0, 3) != 0);
                default: next_ready = ($urandom_range(0, 3) == 0);
            endcase
        end
        i_ready <= next_ready;
    end

    initial begin
        int unsigned n;
        int unsigned r;
        logic        drain_done;
        n = 0;
        drain_done = 1'b0;

        // unknown types, both ends of the byte range
        host_bytes_q.push_back('{8'h00, 1'b0});
        host_bytes_q.push_back('{8'hFF, 1'b0});
        host_bytes_q.push_back('{8'h04, 1'b0});
        void'(queue_packet(TYPE_CMD, 16'd0, 1'b0));
        void'(queue_packet(TYPE_SCO, 16'd1, 1'b0));
        void'(queue_packet(TYPE_ACL, 16'd0, 1'b0));
        void'(queue_packet(TYPE_ACL, 16'd2, 1'b0));

        while (n < 60) begin
            r = $urandom_range(0, 9);
            if (r < 2) begin
                host_bytes_q.push_back('{8'($urandom_range(0, 255)), 1'b0});
            end else begin
                n += queue_packet(8'($urandom_range(TYPE_CMD, TYPE_SCO)),
                                  16'($urandom_range(0, 6)), !drain_done && n >= 30);
                if (n >= 30)
                    drain_done = 1'b1;
            end
        end

        // oversized ACL length: the total saturates, and the stream stops
        // partway into the payload
        host_bytes_q.push_back('{TYPE_ACL, 1'b1});
        host_bytes_q.push_back('{8'($urandom_range(0, 255)), 1'b0});
        host_bytes_q.push_back('{8'($urandom_range(0, 255)), 1'b0});
        host_bytes_q.push_back('{8'hFF, 1'b0});
        host_bytes_q.push_back('{8'hFF, 1'b0});
        for (int unsigned i = 0; i < 6; i++)
            host_bytes_q.push_back('{8'($urandom_range(0, 255)), 1'b0});

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (host_bytes_q.size() != 0)
            @(posedge i_clk);
        while (ctrl_words_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
rtl/hci_frm_pkg.sv
rtl/hci_frm_input.sv
rtl/hci_frm_core.sv
rtl/hci_frm_emit.sv
rtl/hci_h4_packet_framer.sv
tb/sv/tb_hci_h4_packet_framer.sv
